[sv/sad_pkg.sv]
// Shared constants and types for the sort-and-deduplicate block.
`default_nettype none
package sad_pkg;
  localparam int MAX_ITEMS = 64;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = 32;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [DW-1:0] word_t;
endpackage
`default_nettype wire

[sv/sort_and_deduplicate.sv]
// Sort-and-deduplicate: collects a set of signed values, sorts them, emits distinct ones.
// Usage:
//   s_axis carries one value per transaction (tdata = in_value, tlast = in_last).
//   Loading accepts one value per cycle; values past MAX_ITEMS are dropped and flagged.
//   The transaction with tlast closes the set. The block then sorts the store in
//   place with an insertion sort over one RAM (one read and one write port). Each
//   outer step passes through index, read and compare states, and each shift
//   repeats the read and compare. Afterwards the store is swept once, each stored
//   value passing through read, wait and check states; each distinct value goes
//   out on m_axis, ascending.
//   The last result has tlast=1, distinct_count and overflowed set.
//   m_axis uses a one-entry output register; when the receiver stalls the sweep
//   holds. s_axis_tready is low from the closing transaction until the last result
//   is loaded into the output register.
//   Reset (rst, synchronous) empties the set; no clearing pass is needed.
`default_nettype none
module sort_and_deduplicate
  import sad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] in_value
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // [31:0] out_value, [38:32] distinct_count,
                                           // [39] overflowed
  output logic             m_axis_tlast    // out_last
);
  typedef enum logic [2:0] {
    LOAD, S_RD, S_CMP, S_WR, E_RD, E_WAIT, E_CHK
  } state_t;

  state_t state;
  cnt_t   fill_count;
  logic   overflow_seen;
  cnt_t   i_idx;      // insertion outer index
  cnt_t   j_idx;      // shifting position
  word_t  key;
  cnt_t   e_idx;      // emit sweep index
  word_t  prev;
  logic   have_prev;
  cnt_t   dcount;
  word_t  pend;       // value waiting to see whether it is the largest
  logic   pend_v;

  logic   we;
  addr_t  waddr, raddr;
  word_t  wdata, rdata;

  sad_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic acc_in, out_free, out_load;
  assign acc_in   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == LOAD);
  // a result enters the output register this cycle
  assign out_load = (state == E_CHK) && out_free &&
                    ((e_idx == fill_count) || (pend_v && !(have_prev && rdata == prev)));

  function automatic logic slt(word_t a, word_t b);
    return $signed(a) < $signed(b);
  endfunction

  always_comb begin
    we    = 1'b0;
    waddr = fill_count[AW-1:0];
    wdata = s_axis_tdata;
    raddr = '0;
    unique case (state)
      LOAD: begin
        we = acc_in && (fill_count != cnt_t'(MAX_ITEMS));
      end
      S_RD:  raddr = addr_t'(j_idx - cnt_t'(1));
      S_CMP: begin
        raddr = addr_t'(j_idx - cnt_t'(1));
        waddr = j_idx[AW-1:0];
        if (slt(key, rdata)) begin
          we = 1'b1; wdata = rdata;
        end else begin
          we = 1'b1; wdata = key;
        end
      end
      S_WR: begin
        we = 1'b1; waddr = j_idx[AW-1:0]; wdata = key;
        raddr = i_idx[AW-1:0];
      end
      E_RD, E_WAIT, E_CHK: raddr = e_idx[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      m_axis_tvalid <= 1'b0;
      pend_v        <= 1'b0;
      have_prev     <= 1'b0;
      dcount        <= '0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        LOAD: if (acc_in) begin
          cnt_t n;
          n = fill_count;
          if (fill_count != cnt_t'(MAX_ITEMS)) begin
            n = fill_count + cnt_t'(1);
            fill_count <= n;
          end else begin
            overflow_seen <= 1'b1;
          end
          // key mirrors entry 0 until the sort starts
          if (fill_count == '0) key <= s_axis_tdata;
          if (s_axis_tlast) begin
            i_idx <= cnt_t'(1);
            state <= S_WR;   // S_WR primes: with i=1,j=0 it rewrites entry 0 harmlessly
            j_idx <= '0;
          end
        end
        S_WR: begin
          // entry at j now holds key; fetch next outer element
          if (i_idx >= fill_count) begin
            e_idx <= '0; have_prev <= 1'b0; dcount <= '0; pend_v <= 1'b0;
            state <= E_RD;
          end else begin
            state <= S_RD;
            j_idx <= i_idx;
          end
        end
        S_RD: begin
          // on entry from S_WR, rdata is element i
          if (j_idx == i_idx) key <= rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          if (slt(key, rdata)) begin
            j_idx <= j_idx - cnt_t'(1);
            if (j_idx == cnt_t'(1)) begin
              state <= S_WR;
              i_idx <= i_idx + cnt_t'(1);
            end else begin
              state <= S_RD;
              key   <= key;
            end
          end else begin
            i_idx <= i_idx + cnt_t'(1);
            state <= S_WR;
          end
        end
        E_RD: state <= E_WAIT;
        E_WAIT: state <= E_CHK;
        E_CHK: begin
          if (e_idx == fill_count) begin
            if (out_free) begin
              m_axis_tdata  <= {overflow_seen, dcount, pend};
              m_axis_tlast  <= 1'b1;
              fill_count <= '0; overflow_seen <= 1'b0;
              state <= LOAD;
            end
          end else if (have_prev && rdata == prev) begin
            e_idx <= e_idx + cnt_t'(1);
            state <= E_RD;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              m_axis_tdata  <= {1'b0, 7'd0, pend};
              m_axis_tlast  <= 1'b0;
            end
            pend <= rdata; pend_v <= 1'b1;
            prev <= rdata; have_prev <= 1'b1;
            dcount <= dcount + cnt_t'(1);
            e_idx <= e_idx + cnt_t'(1);
            state <= E_RD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= cnt_t'(MAX_ITEMS)) else $error("fill count out of range");
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[38:32] != 7'd0)
    else $error("last result with zero count");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    state != LOAD |-> !s_axis_tready) else $error("accepting while busy");
`endif
endmodule
`default_nettype wire

[sv/sad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[dv/sad_checker.sv]
// Checker for sort_and_deduplicate: predicts distinct sorted runs and compares results.
`timescale 1ns / 100ps
module sad_checker
  import sad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [6:0]  count;
    logic        ovf;
  } run_entry_t;

  logic [31:0] set_vals[$];
  logic        dropped;
  run_entry_t  expected_runs[$];

  assign pending = expected_runs.size();

  // sort the collected set and queue each distinct value
  task automatic close_set();
    logic [31:0] sorted[$];
    logic [31:0] tmp;
    int          distinct;
    run_entry_t  e;
    sorted = set_vals;
    for (int i = 1; i < sorted.size(); i++) begin
      tmp = sorted[i];
      for (int j = i; j > 0 && $signed(tmp) < $signed(sorted[j-1]); j--) begin
        sorted[j] = sorted[j-1];
        sorted[j-1] = tmp;
      end
    end
    distinct = 0;
    for (int i = 0; i < sorted.size(); i++)
      if (i == 0 || sorted[i] != sorted[i-1]) distinct++;
    for (int i = 0; i < sorted.size(); i++) begin
      if (i == 0 || sorted[i] != sorted[i-1]) begin
        e.value = sorted[i];
        e.last  = 1'b1;
        for (int k = i + 1; k < sorted.size(); k++)
          if (sorted[k] != sorted[i]) e.last = 1'b0;
        e.count = e.last ? 7'(distinct) : 7'd0;
        e.ovf   = e.last ? dropped : 1'b0;
        expected_runs.push_back(e);
      end
    end
    set_vals.delete();
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    run_entry_t got, exp_e;
    if (rst) begin
      set_vals.delete();
      expected_runs.delete();
      dropped = 1'b0;
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (set_vals.size() < MAX_ITEMS) set_vals.push_back(s_axis_tdata);
        else dropped = 1'b1;
        if (s_axis_tlast) close_set();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tlast, m_axis_tdata[38:32], m_axis_tdata[39]};
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = expected_runs.pop_front();
          if (got !== exp_e) begin
            $display("%0t: mismatch expected value=%h last=%b count=%0d ovf=%b",
                     $time, exp_e.value, exp_e.last, exp_e.count, exp_e.ovf);
            $display("%0t:          actual   value=%h last=%b count=%0d ovf=%b",
                     $time, got.value, got.last, got.count, got.ovf);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/testbench.sv]
// Top of the sort_and_deduplicate testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import sad_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycles = 0;

  always #1 clk = ~clk;

  sort_and_deduplicate dut (.*);
  sad_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > 3000000) begin
      $display("FAIL sort_and_deduplicate");
      $finish;
    end
  end

  // one value transaction; random gaps before it
  task automatic send_value(input logic [31:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_set(input int n, input int mode);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = $urandom_range(7) - 4;
        default: v = {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom())};
      endcase
      send_value(v, i == n - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // single values at the extremes
    send_value(32'h8000_0000, 1'b1);
    send_value(32'h7fff_ffff, 1'b1);
    // duplicates, mixed signs
    send_value(32'd5, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'd0, 1'b1);
    // all equal
    send_value(32'h1234_5678, 1'b0);
    send_value(32'h1234_5678, 1'b1);
    // overflow: store full, last-marked value dropped
    for (int i = 0; i < 66; i++) send_value(32'(65 - i) ^ 32'hAAAA_0000, i == 65);
    // exactly full
    for (int i = 0; i < 64; i++) send_value(32'(i * 3) - 32'd90, i == 63);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int k = 0; k < 2; k++) begin
        int n;
        n = $urandom_range(1, 4);
        send_set(n, $urandom_range(2));
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS sort_and_deduplicate");
    else $display("FAIL sort_and_deduplicate");
    $finish;
  end
endmodule

[sort_and_deduplicate.f]
sv/sad_pkg.sv
sv/sad_ram.sv
sv/sort_and_deduplicate.sv
dv/sad_checker.sv
dv/testbench.sv
